// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a consequence on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/mrpt_pkg.sv -----
// Package: widths and defaults for the probable-prime tester
`default_nettype none
package mrpt_pkg;
    localparam int unsigned WIDTH_DEF  = 32;
    localparam int unsigned ROUNDS_DEF = 5;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned WORD_COUNT = 5;

    // operation codes for the shared modular unit
    typedef enum logic [1:0] {
        t_OP_MUL = 2'd0,
        t_OP_RED = 2'd1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_ctl;
endpackage
`default_nettype wire

// ----- design/mrpt_if.sv -----
// Interface: valid/ready channel carrying a payload
`default_nettype none
interface mrpt_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/mrpt_modunit.sv -----
// Shared modular unit: bit-serial multiply mod m and reduce mod m
`default_nettype none
`include "assert_macros.svh"
module mrpt_modunit #(
    parameter int unsigned WIDTH = mrpt_pkg::WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mrpt_pkg::t_unit_ctl i_ctl,
    input  wire logic [WIDTH-1:0]  i_x,
    input  wire logic [((WIDTH > mrpt_pkg::WORD_W) ? WIDTH : mrpt_pkg::WORD_W)-1:0] i_y,
    input  wire logic [WIDTH-1:0]  i_m,
    output logic                   o_done,
    output logic [WIDTH-1:0]       o_res
);
    // y operand covers both a residue and a full random word
    localparam int unsigned YW = (WIDTH > mrpt_pkg::WORD_W) ? WIDTH : mrpt_pkg::WORD_W;
    localparam int unsigned CW = $clog2(YW + 1);

    logic [WIDTH-1:0] r_acc, r_term, r_m;
    logic [YW-1:0]    r_y;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_red;
    logic [WIDTH-1:0] n_term2, n_accadd, n_shift;
    logic [WIDTH:0]   w_dbl, w_sum, w_sh;

    // modular add/double: operands stay below m
    always_comb begin
        w_dbl   = {1'b0, r_term} + {1'b0, r_term};
        n_term2 = (w_dbl >= {1'b0, r_m}) ? WIDTH'(w_dbl - {1'b0, r_m}) : w_dbl[WIDTH-1:0];
        w_sum   = {1'b0, r_acc} + {1'b0, r_term};
        n_accadd = (w_sum >= {1'b0, r_m}) ? WIDTH'(w_sum - {1'b0, r_m}) : w_sum[WIDTH-1:0];
        // restoring reduction step: shift in one bit of y from the top
        w_sh    = {r_acc, r_y[YW-1]};
        n_shift = (w_sh >= {1'b0, r_m}) ? WIDTH'(w_sh - {1'b0, r_m}) : w_sh[WIDTH-1:0];
    end

    // sequence multiply (LSB first) or reduction (MSB first)
    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_red  <= (i_ctl.op == mrpt_pkg::t_OP_RED);
            r_acc  <= '0;
            r_term <= i_x;
            r_y    <= i_y;
            r_m    <= i_m;
            r_cnt  <= CW'(YW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
                o_res  <= r_acc;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_red) begin
                    r_acc <= n_shift;
                    r_y   <= {r_y[YW-2:0], 1'b0};
                end else begin
                    if (r_y[0]) r_acc <= n_accadd;
                    r_term <= n_term2;
                    r_y    <= {1'b0, r_y[YW-1:1]};
                end
            end
        end
    end

    `ASSERT_NEXT(a_done_ends, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_IMPLY(a_no_restart, i_clk, i_rst_n, r_busy && r_cnt != '0, !i_ctl.start)
endmodule
`default_nettype wire

// ----- design/miller_rabin_prime_test.sv -----
// Top level: Miller-Rabin probable-prime tester
// Takes a candidate and five random words; returns one verdict beat per candidate.
// One shared bit-serial modular unit does every multiply and the base reduction;
// a round needs up to about 2*WIDTH operations (the power plus the squarings
// after it); small and even candidates are answered straight from the split
// step without using the unit.
// The input is not ready while a candidate is under test.
`default_nettype none
`include "assert_macros.svh"
module miller_rabin_prime_test #(
    parameter int unsigned WIDTH  = mrpt_pkg::WIDTH_DEF,
    parameter int unsigned ROUNDS = mrpt_pkg::ROUNDS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    mrpt_if.sink     i_in,
    mrpt_if.source   o_out
);
    localparam int unsigned SW = $clog2(WIDTH + 1);
    localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int unsigned YW = (WIDTH > mrpt_pkg::WORD_W) ? WIDTH : mrpt_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SPLIT, S_BASE, S_BASE_W, S_POW, S_POW_W1, S_POW_W2,
        S_CHK, S_SQ_W, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic [WIDTH-1:0] r_n, r_r, r_e, r_acc, r_sq, r_x, r_m;
    logic [YW-1:0]    r_y;
    logic [SW-1:0]    r_s, r_j;
    logic [RW-1:0]    r_round;
    logic [2:0]       r_widx;
    logic [mrpt_pkg::WORD_W-1:0] r_words [mrpt_pkg::WORD_COUNT];
    logic             r_verdict, r_outv;
    mrpt_pkg::t_unit_ctl r_ctl;
    logic             w_done;
    logic [WIDTH-1:0] w_res, w_nm1;
    logic [YW-1:0]    w_word;

    assign w_nm1 = r_n - 1'b1;
    // full word, zero-extended to the reduction width
    assign w_word = YW'(r_words[r_widx]);

    mrpt_modunit #(.WIDTH(WIDTH)) u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_ctl),
        .i_x(r_x), .i_y(r_y), .i_m(r_m), .o_done(w_done), .o_res(w_res)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_outv;
    assign o_out.data       = r_verdict;

    // sequence the test
    always_ff @(posedge i_clk) begin
        r_ctl.start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_outv  <= 1'b0;
            r_ctl   <= '{start: 1'b0, op: mrpt_pkg::t_OP_MUL};
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_n      <= WIDTH'(i_in.data.candidate);
                        r_words  <= '{i_in.data.witness_word_0, i_in.data.witness_word_1,
                                      i_in.data.witness_word_2, i_in.data.witness_word_3,
                                      i_in.data.witness_word_4};
                        r_state  <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_round <= '0;
                    r_widx  <= '0;
                    r_verdict <= 1'b1;
                    r_r <= w_nm1;
                    r_s <= '0;
                    if (r_n == WIDTH'(2) || r_n == WIDTH'(3)) begin
                        r_verdict <= 1'b1; r_outv <= 1'b1; r_state <= S_OUT;
                    end else if (r_n < WIDTH'(2) || !r_n[0]) begin
                        r_verdict <= 1'b0; r_outv <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    // strip factors of two, one per cycle
                    if (!r_r[0]) begin
                        r_r <= {1'b0, r_r[WIDTH-1:1]};
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_x <= '0; r_y <= w_word; r_m <= r_n - WIDTH'(3);
                        r_ctl <= '{start: 1'b1, op: mrpt_pkg::t_OP_RED};
                        r_state <= S_BASE_W;
                    end
                end
                S_BASE_W: begin
                    if (w_done) begin
                        r_sq <= w_res + WIDTH'(2);
                        r_acc <= WIDTH'(1);
                        r_e <= r_r;
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    r_m <= r_n;
                    if (r_e == '0) begin
                        r_j <= SW'(1);
                        r_state <= S_CHK;
                    end else if (r_e[0]) begin
                        r_x <= r_acc; r_y <= YW'(r_sq);
                        r_ctl <= '{start: 1'b1, op: mrpt_pkg::t_OP_MUL};
                        r_state <= S_POW_W1;
                    end else begin
                        r_x <= r_sq; r_y <= YW'(r_sq);
                        r_ctl <= '{start: 1'b1, op: mrpt_pkg::t_OP_MUL};
                        r_state <= S_POW_W2;
                    end
                end
                S_POW_W1: begin
                    if (w_done) begin
                        r_acc <= w_res;
                        r_x <= r_sq; r_y <= YW'(r_sq);
                        r_ctl <= '{start: 1'b1, op: mrpt_pkg::t_OP_MUL};
                        r_state <= S_POW_W2;
                    end
                end
                S_POW_W2: begin
                    if (w_done) begin
                        r_sq <= w_res;
                        r_e  <= {1'b0, r_e[WIDTH-1:1]};
                        r_state <= S_POW;
                    end
                end
                S_CHK: begin
                    // first check uses the power itself
                    if (r_acc == w_nm1 || (r_j == SW'(1) && r_acc == WIDTH'(1))) begin
                        r_state <= S_NEXT;
                    end else if (r_acc == WIDTH'(1) || r_j >= r_s) begin
                        r_verdict <= 1'b0; r_outv <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_x <= r_acc; r_y <= YW'(r_acc);
                        r_ctl <= '{start: 1'b1, op: mrpt_pkg::t_OP_MUL};
                        r_state <= S_SQ_W;
                    end
                end
                S_SQ_W: begin
                    if (w_done) begin
                        r_acc <= w_res;
                        r_j <= r_j + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                S_NEXT: begin
                    if (r_round == RW'(ROUNDS - 1)) begin
                        r_outv <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_widx <= (r_widx == 3'(mrpt_pkg::WORD_COUNT - 1)) ? '0 : r_widx + 1'b1;
                        r_state <= S_BASE;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_outv <= 1'b0; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_out_only_in_out, i_clk, i_rst_n, r_outv, r_state == S_OUT)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == S_SPLIT)
    `ASSERT_IMPLY(a_idle_no_out, i_clk, i_rst_n, r_state == S_IDLE, !r_outv)
endmodule
`default_nettype wire
